// ===== rtl/nsp_pkg.sv =====
// Package for the nearest segment picker: command codes, sequencer states,
// datapath command and status structs, and fixed field widths.
// No dependencies.
package nsp_pkg;

  // Fixed widths of the result fields and the configuration register.
  localparam int DIST_W    = 42;
  localparam int CFG_W     = 12;
  localparam int SEL_W     = 16;
  localparam int T_W       = 17;
  localparam int FRAC_BITS = 8;
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(10);
  localparam logic [T_W-1:0]    T_ONE_Q16  = T_W'(65536);
  localparam int                ROUND_HALF = 2048;
  localparam int                ROUND_SHIFT = 12;

  // Command codes on the input channel.
  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_SEGMENT = 2'd1,
    CMD_NODE    = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  // Operand pairs of the shared multiplier.
  typedef enum logic [3:0] {
    MUL_DX_DX,
    MUL_DY_DY,
    MUL_WX_DX,
    MUL_WY_DY,
    MUL_WX_WX,
    MUL_WY_WY,
    MUL_T_DX,
    MUL_T_DY,
    MUL_Q_Q
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    T_HOLD,
    T_ZERO,
    T_ONE,
    T_DIV_INIT
  } t_op_t;

  typedef enum logic [1:0] {
    CMP_NONE,
    CMP_SEG,
    CMP_PT_LANE,
    CMP_NODE
  } cmp_op_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_SQDX,
    S_SQDY,
    S_L2,
    S_DOTX,
    S_DOTY,
    S_DOT,
    S_CHK,
    S_DIV,
    S_TX,
    S_EX,
    S_QX,
    S_TY,
    S_EY,
    S_QY,
    S_SUM,
    S_SCMP,
    S_SQWX,
    S_SQWY,
    S_PSUM,
    S_PCMP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     l2_load;
    t_op_t    t_op;
    logic     div_step;
    logic     q_load;
    logic     q_y;
    cmp_op_t  cmp_op;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic l2_zero;
    logic dot_le0;
    logic dot_ge;
  } dp_stat_t;

endpackage

// ===== rtl/nsp_datapath.sv =====
// Datapath of the nearest segment picker: query state, shared multiplier,
// accumulator, restoring divider for t, rounding and the best-distance compare.
// Depends on nsp_pkg.
module nsp_datapath import nsp_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_W-1:0]             cfg_data,
  input  cmd_t                         cmd,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic [ID_BITS-1:0]           item_id,
  input  dp_ctl_t                      ctl,
  output dp_stat_t                     stat,
  output logic                         lane_found,
  output logic [SEL_W-1:0]             lane_sel,
  output logic                         node_found,
  output logic [SEL_W-1:0]             node_sel,
  output logic [DIST_W-1:0]            best_dist_sq
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int LW = 2 * CW + 3;
  localparam int RW = LW + 1;
  localparam int AW = 2 * CW + 14;
  localparam int MW = (CW + 7 > T_W + 1) ? CW + 7 : T_W + 1;
  localparam int PW = 2 * MW;
  localparam int EW = CW + 19;
  localparam int QW = CW + 6;
  localparam int XW = (AW + FRAC_BITS > DIST_W + 1) ? AW + FRAC_BITS : DIST_W + 1;

  logic [CFG_W-1:0]     max_pick_distance;
  logic signed [CW-1:0] click_x;
  logic signed [CW-1:0] click_y;
  logic [DIST_W-1:0]    best_sq;
  logic                 lane_valid;
  logic [ID_BITS-1:0]   lane_hold;
  logic                 node_valid;
  logic [ID_BITS-1:0]   node_hold;

  logic signed [DW-1:0] dx, dy, wx, wy;
  logic [ID_BITS-1:0]   id_reg;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [LW-1:0]        l2;
  logic [RW-1:0]        rem;
  logic [T_W-1:0]       t;
  logic [QW-1:0]        q;

  logic signed [MW-1:0] ma, mb;
  logic signed [AW-1:0] prod_a;
  logic [RW-1:0]        rem_sh;
  logic signed [EW-1:0] err;
  logic signed [EW-1:0] err_mag;
  logic [EW-1:0]        q_sum;
  logic [XW-1:0]        cmp_w;
  logic [DIST_W-1:0]    d42;
  logic                 win;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pick_distance <= CFG_RESET;
    end else if (cfg_we) begin
      max_pick_distance <= cfg_data;
    end
  end

  // Operand capture for segments and nodes.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_reg <= item_id;
      if (cmd == CMD_SEGMENT) begin
        dx <= DW'(x1) - DW'(x0);
        dy <= DW'(y1) - DW'(y0);
        wx <= DW'(click_x) - DW'(x0);
        wy <= DW'(click_y) - DW'(y0);
      end else begin
        dx <= dx;
        dy <= dy;
        wx <= DW'(x0) - DW'(click_x);
        wy <= DW'(y0) - DW'(click_y);
      end
    end
  end

  // Shared multiplier operand select.
  always_comb begin
    ma = MW'(dx);
    mb = MW'(dx);
    case (ctl.mul_sel)
      MUL_DX_DX: begin ma = MW'(dx); mb = MW'(dx); end
      MUL_DY_DY: begin ma = MW'(dy); mb = MW'(dy); end
      MUL_WX_DX: begin ma = MW'(wx); mb = MW'(dx); end
      MUL_WY_DY: begin ma = MW'(wy); mb = MW'(dy); end
      MUL_WX_WX: begin ma = MW'(wx); mb = MW'(wx); end
      MUL_WY_WY: begin ma = MW'(wy); mb = MW'(wy); end
      MUL_T_DX:  begin ma = MW'($signed({1'b0, t})); mb = MW'(dx); end
      MUL_T_DY:  begin ma = MW'($signed({1'b0, t})); mb = MW'(dy); end
      MUL_Q_Q:   begin ma = MW'($signed({1'b0, q})); mb = MW'($signed({1'b0, q})); end
      default:   begin ma = MW'(dx); mb = MW'(dx); end
    endcase
  end

  assign prod_a = AW'(prod);

  // Product register and accumulator.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= ma * mb;
    end
    case (ctl.acc_op)
      ACC_LOAD: acc <= prod_a;
      ACC_ADD:  acc <= acc + prod_a;
      default:  acc <= acc;
    endcase
    if (ctl.l2_load) begin
      l2 <= acc[LW-1:0];
    end
  end

  // Clamp decisions on the projection.
  assign stat.l2_zero = (l2 == '0);
  assign stat.dot_le0 = acc[AW-1] || (acc == '0);
  assign stat.dot_ge  = !acc[AW-1] && ($unsigned(acc) >= AW'(l2));

  // Restoring divider: one quotient bit of t per step.
  assign rem_sh = {rem[RW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    case (ctl.t_op)
      T_ZERO:     t <= '0;
      T_ONE:      t <= T_ONE_Q16;
      T_DIV_INIT: begin
        t   <= '0;
        rem <= $unsigned(acc[RW-1:0]);
      end
      default: begin
        if (ctl.div_step) begin
          if (rem_sh >= RW'(l2)) begin
            rem <= rem_sh - RW'(l2);
            t   <= {t[T_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            t   <= {t[T_W-2:0], 1'b0};
          end
        end
      end
    endcase
  end

  // Per-axis error in Q16, rounded half up to Q4.
  assign err     = ((ctl.q_y ? EW'(wy) : EW'(wx)) <<< 16) - EW'(prod);
  assign err_mag = err[EW-1] ? -err : err;
  assign q_sum   = $unsigned(err_mag) + EW'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (ctl.q_load) begin
      q <= q_sum[QW+ROUND_SHIFT-1:ROUND_SHIFT];
    end
  end

  // Candidate distance, saturated, against the best so far.
  always_comb begin
    if (ctl.cmp_op == CMP_SEG) begin
      cmp_w = XW'($unsigned(acc));
    end else begin
      cmp_w = XW'({$unsigned(acc), {FRAC_BITS{1'b0}}});
    end
    d42 = (cmp_w > XW'(DIST_MAX)) ? DIST_MAX : cmp_w[DIST_W-1:0];
    win = (ctl.cmp_op != CMP_NONE) && (d42 < best_sq);
  end

  // Query state.
  always_ff @(posedge clk) begin
    if (rst) begin
      click_x    <= '0;
      click_y    <= '0;
      best_sq    <= '0;
      lane_valid <= 1'b0;
      lane_hold  <= '0;
      node_valid <= 1'b0;
      node_hold  <= '0;
    end else if (ctl.load && cmd == CMD_BEGIN) begin
      click_x    <= x0;
      click_y    <= y0;
      best_sq    <= DIST_W'({(2 * CFG_W)'(max_pick_distance) * (2 * CFG_W)'(max_pick_distance),
                             {FRAC_BITS{1'b0}}});
      lane_valid <= 1'b0;
      lane_hold  <= '0;
      node_valid <= 1'b0;
      node_hold  <= '0;
    end else if (win) begin
      best_sq <= d42;
      if (ctl.cmp_op == CMP_NODE) begin
        lane_valid <= 1'b0;
        lane_hold  <= '0;
        node_valid <= 1'b1;
        node_hold  <= id_reg;
      end else begin
        lane_valid <= 1'b1;
        lane_hold  <= id_reg;
      end
    end
  end

  // Result register, loaded by an end transaction.
  always_ff @(posedge clk) begin
    if (ctl.load && cmd == CMD_END) begin
      lane_found   <= lane_valid;
      lane_sel     <= lane_valid ? SEL_W'(lane_hold) : '0;
      node_found   <= node_valid;
      node_sel     <= node_valid ? SEL_W'(node_hold) : '0;
      best_dist_sq <= best_sq;
    end
  end

`ifndef SYNTH
  // The remainder stays below the divisor after every step.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |=> (rem < RW'(l2)))
    else $error("divider remainder out of range");

  // A winning compare stores the candidate distance.
  a_win_store: assert property (@(posedge clk) disable iff (rst)
    (win && !ctl.load) |=> (best_sq == $past(d42)))
    else $error("best distance not updated on a win");

  // The projection parameter never exceeds one when the error is rounded.
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    ctl.q_load |-> (t <= T_ONE_Q16))
    else $error("projection parameter out of range");
`endif

endmodule

// ===== rtl/nsp_ctrl.sv =====
// Controller of the nearest segment picker: sequences the datapath through
// the segment and point steps and owns the input and output channel handshakes.
// Depends on nsp_pkg.
module nsp_ctrl import nsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  cmd_t     in_cmd,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             is_node, is_node_next;
  logic             out_valid_next;
  logic             accept;

  assign in_ready = (state == S_IDLE) &&
                    ((in_cmd != CMD_END) || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      is_node   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      is_node   <= is_node_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    is_node_next   = is_node;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_SEGMENT: begin
              state_next   = S_SQDX;
              is_node_next = 1'b0;
            end
            CMD_NODE: begin
              state_next   = S_SQWX;
              is_node_next = 1'b1;
            end
            CMD_END:   out_valid_next = 1'b1;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SQDX: state_next = S_SQDY;
      S_SQDY: state_next = S_L2;
      S_L2:   state_next = S_DOTX;
      S_DOTX: state_next = S_DOTY;
      S_DOTY: state_next = S_DOT;
      S_DOT:  state_next = S_CHK;
      S_CHK: begin
        cnt_next = '0;
        if (stat.l2_zero) begin
          state_next = S_SQWX;
        end else if (stat.dot_le0 || stat.dot_ge) begin
          state_next = S_TX;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_TX;
        end
      end
      S_TX:   state_next = S_EX;
      S_EX:   state_next = S_QX;
      S_QX:   state_next = S_TY;
      S_TY:   state_next = S_EY;
      S_EY:   state_next = S_QY;
      S_QY:   state_next = S_SUM;
      S_SUM:  state_next = S_SCMP;
      S_SCMP: state_next = S_IDLE;
      S_SQWX: state_next = S_SQWY;
      S_SQWY: state_next = S_PSUM;
      S_PSUM: state_next = S_PCMP;
      S_PCMP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl          = '0;
    ctl.mul_sel  = MUL_DX_DX;
    ctl.acc_op   = ACC_HOLD;
    ctl.t_op     = T_HOLD;
    ctl.cmp_op   = CMP_NONE;
    ctl.load     = accept;
    unique case (state)
      S_SQDX: begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_DX_DX; end
      S_SQDY: begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_DY_DY; ctl.acc_op = ACC_LOAD; end
      S_L2:   ctl.acc_op = ACC_ADD;
      S_DOTX: begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_WX_DX; ctl.l2_load = 1'b1; end
      S_DOTY: begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_WY_DY; ctl.acc_op = ACC_LOAD; end
      S_DOT:  ctl.acc_op = ACC_ADD;
      S_CHK: begin
        if (stat.l2_zero) begin
          ctl.t_op = T_HOLD;
        end else if (stat.dot_le0) begin
          ctl.t_op = T_ZERO;
        end else if (stat.dot_ge) begin
          ctl.t_op = T_ONE;
        end else begin
          ctl.t_op = T_DIV_INIT;
        end
      end
      S_DIV:  ctl.div_step = 1'b1;
      S_TX:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_T_DX; end
      S_EX:   ctl.q_load = 1'b1;
      S_QX:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_Q_Q; end
      S_TY:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_T_DY; ctl.acc_op = ACC_LOAD; end
      S_EY:   begin ctl.q_load = 1'b1; ctl.q_y = 1'b1; end
      S_QY:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_Q_Q; end
      S_SUM:  ctl.acc_op = ACC_ADD;
      S_SCMP: ctl.cmp_op = CMP_SEG;
      S_SQWX: begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_WX_WX; end
      S_SQWY: begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_WY_WY; ctl.acc_op = ACC_LOAD; end
      S_PSUM: ctl.acc_op = ACC_ADD;
      S_PCMP: ctl.cmp_op = is_node ? CMP_NODE : CMP_PT_LANE;
      default: ctl.mul_en = 1'b0;
    endcase
  end

`ifndef SYNTH
  // No transaction is taken while an item is in progress.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input taken while busy");

  // The divider runs exactly its step count.
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == CNT_W'(DIV_STEPS - 1)) |=> (state == S_TX))
    else $error("divider step count wrong");

  // An end transaction always presents a result.
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == CMD_END) |=> out_valid)
    else $error("end transaction without result");
`endif

endmodule

// ===== rtl/nearest_segment_picker_unit.sv =====
// Top level of the nearest segment picker: joins the controller and datapath.
// Depends on nsp_pkg, nsp_ctrl and nsp_datapath.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    cmd, x0, y0, x1, y1, item_id
//   out      output     out_valid / out_ready  lane_found, lane_sel, node_found,
//                                               node_sel, best_dist_sq
//   cfg      input      cfg_valid / cfg_ready  cfg_data (max_pick_distance)
//
// A segment runs the squared-length and dot-product steps, then the bit-serial divider
// for t and the per-axis error steps; when t clamps to 0 or 1 the divider is skipped,
// and a zero-length segment goes to the point steps. A node runs the point steps only;
// begin and end need no steps. The shared multiplier is used at most once per step.
// Reset clears the query state and loads a pick radius of 10 pixels.
// Input waits while an item is in progress, and an end also while the last result is held.
module nearest_segment_picker_unit import nsp_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic [ID_BITS-1:0]           item_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         lane_found,
  output logic [SEL_W-1:0]             lane_sel,
  output logic                         node_found,
  output logic [SEL_W-1:0]             node_sel,
  output logic [DIST_W-1:0]            best_dist_sq,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_W-1:0]             cfg_data
);

  dp_ctl_t  ctl;
  dp_stat_t stat;
  cmd_t     cmd_code;

  assign cmd_code  = cmd_t'(cmd);
  assign cfg_ready = 1'b1;

  nsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (cmd_code),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  nsp_datapath #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd_code),
    .x0           (x0),
    .y0           (y0),
    .x1           (x1),
    .y1           (y1),
    .item_id      (item_id),
    .ctl          (ctl),
    .stat         (stat),
    .lane_found   (lane_found),
    .lane_sel     (lane_sel),
    .node_found   (node_found),
    .node_sel     (node_sel),
    .best_dist_sq (best_dist_sq)
  );

endmodule

// ===== tb/tb_nearest_segment_picker_unit.sv =====
// Testbench for nearest_segment_picker_unit: directed and random pick queries,
// checked against a built-in fixed-point predictor. Depends on nsp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_nearest_segment_picker_unit;
  import nsp_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  // Expected content of one pick report.
  typedef struct {
    bit              lane_found;
    bit [SEL_W-1:0]  lane_sel;
    bit              node_found;
    bit [SEL_W-1:0]  node_sel;
    bit [DIST_W-1:0] dist_sq;
  } pick_report_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [1:0] cmd;
  logic signed [15:0] x0, y0, x1, y1;
  logic [15:0] item_id;
  logic out_valid, out_ready;
  logic lane_found, node_found;
  logic [SEL_W-1:0] lane_sel, node_sel;
  logic [DIST_W-1:0] best_dist_sq;
  logic cfg_valid, cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // Predictor state: a copy of the query state and the pick radius.
  longint          pick_radius;
  longint          click_px, click_py;
  longint unsigned bound_sq;
  bit              lane_won, node_won;
  bit [15:0]       lane_id_hold, node_id_hold;

  pick_report_t pending_reports[$];
  int  fail_count;
  int  report_count;
  int  item_count;
  int  cycle_count;
  bit  gaps_on;

  nearest_segment_picker_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .x0(x0), .y0(y0), .x1(x1), .y1(y1), .item_id(item_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .lane_found(lane_found), .lane_sel(lane_sel),
    .node_found(node_found), .node_sel(node_sel),
    .best_dist_sq(best_dist_sq),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("tb_nearest_segment_picker_unit: FAIL");
      $finish;
    end
  end

  function automatic int draw_gap();
    draw_gap = gaps_on ? $urandom_range(0, 5) : 0;
  endfunction

  function automatic longint unsigned clamp_dist(longint unsigned v);
    clamp_dist = (v > longint'(DIST_MAX)) ? longint'(DIST_MAX) : v;
  endfunction

  function automatic longint unsigned point_dist(longint dx, longint dy);
    point_dist = clamp_dist((dx * dx + dy * dy) << FRAC_BITS);
  endfunction

  // Squares the Q16 error after rounding it half up to Q4.
  function automatic longint unsigned err_sq(longint e);
    longint unsigned q;
    q = ((e < 0 ? -e : e) + ROUND_HALF) >> ROUND_SHIFT;
    err_sq = q * q;
  endfunction

  // Squared distance from the click to a segment, via the clamped Q1.16 t.
  function automatic longint unsigned segment_dist(longint ax, longint ay,
                                                   longint bx, longint by);
    longint dx, dy, wx, wy, len_sq, dot, rem, t;
    dx = bx - ax;
    dy = by - ay;
    wx = click_px - ax;
    wy = click_py - ay;
    len_sq = dx * dx + dy * dy;
    if (len_sq == 0) return point_dist(wx, wy);
    dot = wx * dx + wy * dy;
    if (dot <= 0) begin
      t = 0;
    end else if (dot >= len_sq) begin
      t = 65536;
    end else begin
      rem = dot;
      t = 0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= len_sq) begin
          rem = rem - len_sq;
          t = t | 1;
        end
      end
    end
    segment_dist = clamp_dist(err_sq(wx * 65536 - t * dx) + err_sq(wy * 65536 - t * dy));
  endfunction

  // Updates the query state for one accepted transaction.
  task automatic predict_pick(cmd_t c, logic signed [15:0] a_x, logic signed [15:0] a_y,
                              logic signed [15:0] b_x, logic signed [15:0] b_y,
                              logic [15:0] id);
    longint unsigned d;
    pick_report_t r;
    case (c)
      CMD_BEGIN: begin
        click_px = a_x;
        click_py = a_y;
        bound_sq = (pick_radius * pick_radius) << FRAC_BITS;
        lane_won = 0; lane_id_hold = 0;
        node_won = 0; node_id_hold = 0;
      end
      CMD_SEGMENT: begin
        d = segment_dist(a_x, a_y, b_x, b_y);
        if (d < bound_sq) begin
          bound_sq = d;
          lane_won = 1;
          lane_id_hold = id;
        end
      end
      CMD_NODE: begin
        d = point_dist(longint'(a_x) - click_px, longint'(a_y) - click_py);
        if (d < bound_sq) begin
          bound_sq = d;
          lane_won = 0; lane_id_hold = 0;
          node_won = 1; node_id_hold = id;
        end
      end
      default: begin
        r.lane_found = lane_won;
        r.lane_sel   = lane_won ? lane_id_hold : '0;
        r.node_found = node_won;
        r.node_sel   = node_won ? node_id_hold : '0;
        r.dist_sq    = bound_sq[DIST_W-1:0];
        pending_reports.push_back(r);
      end
    endcase
  endtask

  // Sends one transaction and waits for it to be accepted, then the gap before the next.
  task automatic send_item(cmd_t c, logic signed [15:0] a_x, logic signed [15:0] a_y,
                           logic signed [15:0] b_x, logic signed [15:0] b_y,
                           logic [15:0] id);
    int gap;
    in_valid <= 1'b1;
    cmd      <= c;
    x0 <= a_x; y0 <= a_y; x1 <= b_x; y1 <= b_y;
    item_id  <= id;
    do @(posedge clk); while (!in_ready);
    predict_pick(c, a_x, a_y, b_x, b_y, id);
    item_count++;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets the block drain, then writes the pick radius.
  task automatic write_radius(int r);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(r);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pick_radius = r;
    @(posedge clk);
  endtask

  // Result receiver with random stalls per transaction.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Compares every accepted report with the oldest expectation.
  always @(posedge clk) begin
    pick_report_t e;
    if (!rst && out_valid && out_ready) begin
      report_count++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report lane=%0d/%0h node=%0d/%0h dist=%0h", $time,
                 lane_found, lane_sel, node_found, node_sel, best_dist_sq);
        fail_count++;
      end else begin
        e = pending_reports.pop_front();
        if (lane_found !== e.lane_found || lane_sel !== e.lane_sel ||
            node_found !== e.node_found || node_sel !== e.node_sel ||
            best_dist_sq !== e.dist_sq) begin
          $display("%0t: expected lane=%0d/%0h node=%0d/%0h dist=%0h", $time,
                   e.lane_found, e.lane_sel, e.node_found, e.node_sel, e.dist_sq);
          $display("%0t: actual   lane=%0d/%0h node=%0d/%0h dist=%0h", $time,
                   lane_found, lane_sel, node_found, node_sel, best_dist_sq);
          fail_count++;
        end
      end
    end
  end

  // Items sent before any begin see the reset state; end repeats without clearing.
  task automatic test_before_begin();
    send_item(CMD_END, 0, 0, 0, 0, 0);
    send_item(CMD_SEGMENT, 0, 0, 0, 0, 16'h1111);
    send_item(CMD_NODE, 0, 0, 0, 0, 16'h2222);
    send_item(CMD_END, 0, 0, 0, 0, 0);
    send_item(CMD_END, 0, 0, 0, 0, 0);
  endtask

  // Hand-picked queries: clamping of t, zero length, ties, node takeover, extremes.
  task automatic test_directed_cases();
    send_item(CMD_BEGIN, 0, 0, 16'h7fff, 16'h7fff, 16'hffff);
    send_item(CMD_SEGMENT, -5, 3, 5, 3, 16'h0001);       // t inside the segment
    send_item(CMD_SEGMENT, 5, 3, -5, 3, 16'h0002);       // same distance: tie keeps lane
    send_item(CMD_SEGMENT, 2, 1, 9, 1, 16'h0003);        // t clamps to 0
    send_item(CMD_SEGMENT, -9, 2, -1, 1, 16'h0004);      // t clamps to 1
    send_item(CMD_SEGMENT, 1, 1, 1, 1, 16'h0005);        // zero length
    send_item(CMD_END, 0, 0, 0, 0, 0);
    send_item(CMD_NODE, 0, 1, 0, 0, 16'hbeef);           // node clears the lane
    send_item(CMD_NODE, 1, 0, 0, 0, 16'h0bad);           // tie keeps the node
    send_item(CMD_SEGMENT, 3, 7, 4, 9, 16'hffff);
    send_item(CMD_END, 0, 0, 0, 0, 0);
    send_item(CMD_BEGIN, 16'sh8000, 16'sh8000, 0, 0, 0);
    send_item(CMD_SEGMENT, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff);
    send_item(CMD_SEGMENT, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'h8000);
    send_item(CMD_SEGMENT, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'h7fff);
    send_item(CMD_NODE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
    send_item(CMD_NODE, 16'sh8001, 16'sh8000, 0, 0, 16'h8001);
    send_item(CMD_END, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
  endtask

  // One query per radius setting, sweeping the extremes of the register.
  task automatic test_radius_sweep();
    int radii[5] = '{0, 4095, 1, 2048, 10};
    foreach (radii[i]) begin
      write_radius(radii[i]);
      send_item(CMD_BEGIN, 100, -100, 0, 0, 0);
      send_item(CMD_NODE, 100, -100, 0, 0, 16'h00aa);    // zero distance never beats radius 0
      send_item(CMD_SEGMENT, 90, -100, 90, -80, 16'h00bb);
      send_item(CMD_NODE, 16'sh8000, 16'sh7fff, 0, 0, 16'h00cc);
      send_item(CMD_END, 0, 0, 0, 0, 0);
    end
  endtask

  // Coordinate near the click, wrapping at the field width.
  function automatic logic signed [15:0] near_coord(longint base, int span);
    near_coord = 16'(base + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Mostly well-formed queries with random content, plus noise.
  task automatic test_random_queries(int n_items);
    int span, n_body;
    logic signed [15:0] cx, cy;
    while (item_count < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
        continue;
      end
      cx = 16'($urandom);
      cy = 16'($urandom);
      span = 2 * pick_radius + 4;
      send_item(CMD_BEGIN, cx, cy, 16'($urandom), 16'($urandom), 16'($urandom));
      n_body = $urandom_range(1, 8);
      for (int k = 0; k < n_body; k++) begin
        if ($urandom_range(0, 2) != 0)
          send_item(CMD_SEGMENT, near_coord(cx, span), near_coord(cy, span),
                    near_coord(cx, 3 * span), near_coord(cy, 3 * span), 16'($urandom));
        else
          send_item(CMD_NODE, near_coord(cx, span), near_coord(cy, span),
                    16'($urandom), 16'($urandom), 16'($urandom));
      end
      send_item(CMD_END, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
      if ($urandom_range(0, 15) == 0) write_radius($urandom_range(0, 4095));
      if ($urandom_range(0, 31) == 0) gaps_on = !gaps_on;
    end
  endtask

  // Test sequence.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0; cmd = CMD_BEGIN;
    x0 = '0; y0 = '0; x1 = '0; y1 = '0; item_id = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    fail_count = 0; report_count = 0; item_count = 0; cycle_count = 0;
    gaps_on = 1'b0;
    pick_radius = CFG_RESET;
    click_px = 0; click_py = 0; bound_sq = 0;
    lane_won = 0; node_won = 0; lane_id_hold = 0; node_id_hold = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_before_begin();
    test_directed_cases();
    gaps_on = 1'b1;
    test_radius_sweep();
    write_radius(6);
    test_random_queries(item_count + 600);

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d transactions and checked %0d pick reports", item_count, report_count);
    $display("over several pick radii, with random gaps and stalls on both sides.");
    if (fail_count == 0)
      $display("tb_nearest_segment_picker_unit: PASS");
    else
      $display("tb_nearest_segment_picker_unit: FAIL");
    $finish;
  end

endmodule
